### rtl/core/ffua_pkg.sv
// Shared types, constants and codes for the first-fit unit allocator.
package ffua_pkg;

    localparam int UNITS      = 256;
    localparam int UNIT_BYTES = 64;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
    localparam int IDX_W      = $clog2(UNITS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int SIZE_W     = 16;
    localparam int REQ_W      = SIZE_W + 1 - UNIT_SHIFT;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_NO_FIT = 2'd1;
    localparam logic [1:0] STATUS_BAD    = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] size_bytes;
        logic [IDX_W-1:0]  unit_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] start_unit;
        logic [CNT_W-1:0] used_units;
        logic [CNT_W-1:0] free_extents;
    } result_t;

    // One word of the extent store: free flag and length at a start unit.
    typedef struct packed {
        logic             free;
        logic [CNT_W-1:0] len;
    } ext_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] lf_raddr;
        logic             lf_we;
        logic [IDX_W-1:0] lf_waddr;
        ext_word_t        lf_wdata;
        logic [IDX_W-1:0] hd_raddr;
        logic             hd_we;
        logic [IDX_W-1:0] hd_waddr;
        logic [IDX_W-1:0] hd_wdata;
        logic [IDX_W-1:0] fo_raddr;
        logic             fo_we;
        logic [IDX_W-1:0] fo_waddr;
        logic [IDX_W-1:0] fo_wdata;
    } mem_req_t;

    typedef struct packed {
        ext_word_t        lf_rdata;
        logic [IDX_W-1:0] hd_rdata;
        logic [IDX_W-1:0] fo_rdata;
    } mem_rsp_t;

endpackage

### rtl/core/ffua_mem.sv
// Extent length/flag store, extent head store and free-list order store.
module ffua_mem (
    input  logic               clk,
    input  ffua_pkg::mem_req_t req,
    output ffua_pkg::mem_rsp_t rsp
);

    ffua_pkg::ext_word_t           lf_mem [ffua_pkg::UNITS];
    logic [ffua_pkg::IDX_W-1:0]    hd_mem [ffua_pkg::UNITS];
    logic [ffua_pkg::IDX_W-1:0]    fo_mem [ffua_pkg::UNITS];

    always_ff @(posedge clk)
    begin
        if (req.lf_we)
        begin
            lf_mem[req.lf_waddr] <= req.lf_wdata;
        end
        if (req.hd_we)
        begin
            hd_mem[req.hd_waddr] <= req.hd_wdata;
        end
        if (req.fo_we)
        begin
            fo_mem[req.fo_waddr] <= req.fo_wdata;
        end
        rsp.lf_rdata <= lf_mem[req.lf_raddr];
        rsp.hd_rdata <= hd_mem[req.hd_raddr];
        rsp.fo_rdata <= fo_mem[req.fo_raddr];
    end

endmodule

### rtl/core/ffua_ctrl.sv
// Sequencer that walks the free list and updates the extent stores.
module ffua_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  ffua_pkg::cmd_t              cmd,
    input  logic                        cfg_we,
    input  logic [ffua_pkg::CNT_W-1:0]  cfg_data,
    input  ffua_pkg::mem_rsp_t          mrsp,
    output ffua_pkg::mem_req_t          mreq,
    output logic                        busy,
    output logic                        done,
    output ffua_pkg::result_t           result
);

    localparam int IW = ffua_pkg::IDX_W;
    localparam int CW = ffua_pkg::CNT_W;
    localparam int RW = ffua_pkg::REQ_W;
    localparam int SIZE_SUM_W = ffua_pkg::SIZE_W + 1;

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b0000_0000_0001,
        ST_INIT   = 12'b0000_0000_0010,
        ST_IDLE   = 12'b0000_0000_0100,
        ST_A_RDO  = 12'b0000_0000_1000,
        ST_A_CMP  = 12'b0000_0001_0000,
        ST_A_SPL  = 12'b0000_0010_0000,
        ST_SHIFT  = 12'b0000_0100_0000,
        ST_F_RDC  = 12'b0000_1000_0000,
        ST_F_RDN  = 12'b0001_0000_0000,
        ST_F_RDP  = 12'b0010_0000_0000,
        ST_F_SCAN = 12'b0100_0000_0000,
        ST_F_WR   = 12'b1000_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   pool_reg, pool_next;
    logic [CW-1:0]   fc_reg, fc_next;
    logic [CW-1:0]   used_reg, used_next;
    logic [RW-1:0]   units_reg, units_next;
    logic [IW-1:0]   c_reg, c_next;
    logic [CW-1:0]   len_reg, len_next;
    logic [CW-1:0]   nx_reg, nx_next;
    logic [CW-1:0]   nlen_reg, nlen_next;
    logic [IW-1:0]   p_reg, p_next;
    logic [CW-1:0]   plen_reg, plen_next;
    logic            nf_reg, nf_next;
    logic            pf_reg, pf_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   slot_reg, slot_next;
    logic [IW-1:0]   s_reg, s_next;
    logic [1:0]      step_reg, step_next;
    logic [1:0]      status_reg, status_next;
    logic [IW-1:0]   start_reg, start_next;

    logic [SIZE_SUM_W-1:0] size_sum;
    logic [RW-1:0]   req_units;
    logic [CW:0]     prev_end;
    logic [CW-1:0]   idx_inc;

    assign size_sum  = {1'b0, cmd.size_bytes} + SIZE_SUM_W'(ffua_pkg::UNIT_BYTES - 1);
    assign req_units = size_sum[SIZE_SUM_W-1:ffua_pkg::UNIT_SHIFT];
    assign prev_end  = {2'b00, p_reg} + {1'b0, mrsp.lf_rdata.len};
    assign idx_inc   = idx_reg + CW'(1);

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        pool_next   = pool_reg;
        fc_next     = fc_reg;
        used_next   = used_reg;
        units_next  = units_reg;
        c_next      = c_reg;
        len_next    = len_reg;
        nx_next     = nx_reg;
        nlen_next   = nlen_reg;
        p_next      = p_reg;
        plen_next   = plen_reg;
        nf_next     = nf_reg;
        pf_next     = pf_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        s_next      = s_reg;
        step_next   = step_reg;
        status_next = status_reg;
        start_next  = start_reg;
        mreq        = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mreq.lf_we    = 1'b1;
                mreq.lf_waddr = idx_reg[IW-1:0];
                idx_next      = idx_inc;
                if (idx_reg[IW-1:0] == IW'(ffua_pkg::UNITS - 1))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                mreq.lf_we         = 1'b1;
                mreq.lf_waddr      = '0;
                mreq.lf_wdata.free = 1'b1;
                mreq.lf_wdata.len  = pool_reg;
                mreq.hd_we         = 1'b1;
                mreq.hd_waddr      = IW'(pool_reg - CW'(1));
                mreq.fo_we         = 1'b1;
                fc_next            = CW'(1);
                used_next          = '0;
                state_next         = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cfg_we)
                begin
                    if (cfg_data == '0)
                    begin
                        pool_next = CW'(1);
                    end
                    else if (cfg_data > CW'(ffua_pkg::UNITS))
                    begin
                        pool_next = CW'(ffua_pkg::UNITS);
                    end
                    else
                    begin
                        pool_next = cfg_data;
                    end
                    idx_next   = '0;
                    state_next = ST_CLEAR;
                end
                else if (start && !done_reg)
                begin
                    status_next = ffua_pkg::STATUS_OK;
                    start_next  = '0;
                    if (cmd.mode == ffua_pkg::MODE_FREE)
                    begin
                        c_next        = cmd.unit_index;
                        mreq.lf_raddr = cmd.unit_index;
                        if ({1'b0, cmd.unit_index} >= pool_reg)
                        begin
                            status_next = ffua_pkg::STATUS_BAD;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_F_RDC;
                        end
                    end
                    else
                    begin
                        units_next = req_units;
                        if (req_units == '0 || fc_reg == '0)
                        begin
                            status_next = ffua_pkg::STATUS_NO_FIT;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            idx_next      = '0;
                            mreq.fo_raddr = '0;
                            state_next    = ST_A_RDO;
                        end
                    end
                end
            end
            ST_A_RDO:
            begin
                s_next        = mrsp.fo_rdata;
                mreq.lf_raddr = mrsp.fo_rdata;
                state_next    = ST_A_CMP;
            end
            ST_A_CMP:
            begin
                if (RW'(mrsp.lf_rdata.len) >= units_reg)
                begin
                    len_next           = mrsp.lf_rdata.len;
                    mreq.lf_we         = 1'b1;
                    mreq.lf_waddr      = s_reg;
                    mreq.lf_wdata.free = 1'b0;
                    mreq.lf_wdata.len  = CW'(units_reg);
                    used_next          = used_reg + CW'(units_reg);
                    start_next         = s_reg;
                    if (RW'(mrsp.lf_rdata.len) == units_reg)
                    begin
                        if (idx_inc < fc_reg)
                        begin
                            mreq.fo_raddr = idx_inc[IW-1:0];
                            state_next    = ST_SHIFT;
                        end
                        else
                        begin
                            fc_next    = fc_reg - CW'(1);
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        mreq.hd_we    = 1'b1;
                        mreq.hd_waddr = s_reg + IW'(units_reg) - IW'(1);
                        mreq.hd_wdata = s_reg;
                        mreq.fo_we    = 1'b1;
                        mreq.fo_waddr = idx_reg[IW-1:0];
                        mreq.fo_wdata = s_reg + IW'(units_reg);
                        state_next    = ST_A_SPL;
                    end
                end
                else if (idx_inc >= fc_reg)
                begin
                    status_next = ffua_pkg::STATUS_NO_FIT;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    idx_next      = idx_inc;
                    mreq.fo_raddr = idx_inc[IW-1:0];
                    state_next    = ST_A_RDO;
                end
            end
            ST_A_SPL:
            begin
                mreq.lf_we         = 1'b1;
                mreq.lf_waddr      = s_reg + IW'(units_reg);
                mreq.lf_wdata.free = 1'b1;
                mreq.lf_wdata.len  = len_reg - CW'(units_reg);
                mreq.hd_we         = 1'b1;
                mreq.hd_waddr      = s_reg + IW'(len_reg) - IW'(1);
                mreq.hd_wdata      = s_reg + IW'(units_reg);
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_SHIFT:
            begin
                // Read of the entry two ahead overlaps the write of this one.
                mreq.fo_we    = 1'b1;
                mreq.fo_waddr = idx_reg[IW-1:0];
                mreq.fo_wdata = mrsp.fo_rdata;
                idx_next      = idx_inc;
                if (idx_inc + CW'(1) < fc_reg)
                begin
                    mreq.fo_raddr = IW'(idx_inc + CW'(1));
                end
                else
                begin
                    fc_next    = fc_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_F_RDC:
            begin
                if (mrsp.lf_rdata.len == '0 || mrsp.lf_rdata.free)
                begin
                    status_next = ffua_pkg::STATUS_BAD;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    len_next      = mrsp.lf_rdata.len;
                    nx_next       = {1'b0, c_reg} + mrsp.lf_rdata.len;
                    mreq.hd_raddr = c_reg - IW'(1);
                    mreq.lf_raddr = IW'({1'b0, c_reg} + mrsp.lf_rdata.len);
                    state_next    = ST_F_RDN;
                end
            end
            ST_F_RDN:
            begin
                nf_next       = (nx_reg < pool_reg) && mrsp.lf_rdata.free &&
                                (mrsp.lf_rdata.len != '0);
                nlen_next     = mrsp.lf_rdata.len;
                p_next        = mrsp.hd_rdata;
                mreq.lf_raddr = mrsp.hd_rdata;
                state_next    = ST_F_RDP;
            end
            ST_F_RDP:
            begin
                pf_next   = (c_reg != '0) && mrsp.lf_rdata.free &&
                            (mrsp.lf_rdata.len != '0) && (prev_end == {2'b00, c_reg});
                plen_next = mrsp.lf_rdata.len;
                step_next = '0;
                if (nf_reg && fc_reg != '0)
                begin
                    idx_next      = '0;
                    mreq.fo_raddr = '0;
                    state_next    = ST_F_SCAN;
                end
                else
                begin
                    slot_next  = fc_reg;
                    state_next = ST_F_WR;
                end
            end
            ST_F_SCAN:
            begin
                if (mrsp.fo_rdata == nx_reg[IW-1:0])
                begin
                    slot_next  = idx_reg;
                    state_next = ST_F_WR;
                end
                else if (idx_inc >= fc_reg)
                begin
                    slot_next  = fc_reg;
                    state_next = ST_F_WR;
                end
                else
                begin
                    idx_next      = idx_inc;
                    mreq.fo_raddr = idx_inc[IW-1:0];
                end
            end
            ST_F_WR:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd0)
                begin
                    used_next = (used_reg >= len_reg) ? used_reg - len_reg : '0;
                end
                priority if (nf_reg && pf_reg)
                begin
                    if (step_reg == 2'd0)
                    begin
                        mreq.lf_we    = 1'b1;
                        mreq.lf_waddr = nx_reg[IW-1:0];
                        mreq.hd_we    = 1'b1;
                        mreq.hd_waddr = IW'(nx_reg + nlen_reg - CW'(1));
                        mreq.hd_wdata = p_reg;
                    end
                    else if (step_reg == 2'd1)
                    begin
                        mreq.lf_we         = 1'b1;
                        mreq.lf_waddr      = p_reg;
                        mreq.lf_wdata.free = 1'b1;
                        mreq.lf_wdata.len  = plen_reg + len_reg + nlen_reg;
                    end
                    else
                    begin
                        mreq.lf_we    = 1'b1;
                        mreq.lf_waddr = c_reg;
                        if (slot_reg < fc_reg && slot_reg + CW'(1) < fc_reg)
                        begin
                            idx_next      = slot_reg;
                            mreq.fo_raddr = IW'(slot_reg + CW'(1));
                            state_next    = ST_SHIFT;
                        end
                        else
                        begin
                            if (slot_reg < fc_reg)
                            begin
                                fc_next = fc_reg - CW'(1);
                            end
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (nf_reg)
                begin
                    if (step_reg == 2'd0)
                    begin
                        mreq.lf_we    = 1'b1;
                        mreq.lf_waddr = nx_reg[IW-1:0];
                        mreq.hd_we    = 1'b1;
                        mreq.hd_waddr = IW'(nx_reg + nlen_reg - CW'(1));
                        mreq.hd_wdata = c_reg;
                        if (slot_reg < fc_reg)
                        begin
                            mreq.fo_we    = 1'b1;
                            mreq.fo_waddr = slot_reg[IW-1:0];
                            mreq.fo_wdata = c_reg;
                        end
                        else if (!fc_reg[CW-1])
                        begin
                            mreq.fo_we    = 1'b1;
                            mreq.fo_waddr = fc_reg[IW-1:0];
                            mreq.fo_wdata = c_reg;
                            fc_next       = fc_reg + CW'(1);
                        end
                    end
                    else
                    begin
                        mreq.lf_we         = 1'b1;
                        mreq.lf_waddr      = c_reg;
                        mreq.lf_wdata.free = 1'b1;
                        mreq.lf_wdata.len  = len_reg + nlen_reg;
                        done_next          = 1'b1;
                        state_next         = ST_IDLE;
                    end
                end
                else if (pf_reg)
                begin
                    if (step_reg == 2'd0)
                    begin
                        mreq.lf_we         = 1'b1;
                        mreq.lf_waddr      = p_reg;
                        mreq.lf_wdata.free = 1'b1;
                        mreq.lf_wdata.len  = plen_reg + len_reg;
                        mreq.hd_we         = 1'b1;
                        mreq.hd_waddr      = c_reg + IW'(len_reg) - IW'(1);
                        mreq.hd_wdata      = p_reg;
                    end
                    else
                    begin
                        mreq.lf_we    = 1'b1;
                        mreq.lf_waddr = c_reg;
                        done_next     = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    mreq.lf_we         = 1'b1;
                    mreq.lf_waddr      = c_reg;
                    mreq.lf_wdata.free = 1'b1;
                    mreq.lf_wdata.len  = len_reg;
                    if (!fc_reg[CW-1])
                    begin
                        mreq.fo_we    = 1'b1;
                        mreq.fo_waddr = fc_reg[IW-1:0];
                        mreq.fo_wdata = c_reg;
                        fc_next       = fc_reg + CW'(1);
                    end
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
            pool_reg  <= CW'(ffua_pkg::UNITS);
            fc_reg    <= CW'(1);
            used_reg  <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            pool_reg  <= pool_next;
            fc_reg    <= fc_next;
            used_reg  <= used_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        units_reg  <= units_next;
        c_reg      <= c_next;
        len_reg    <= len_next;
        nx_reg     <= nx_next;
        nlen_reg   <= nlen_next;
        p_reg      <= p_next;
        plen_reg   <= plen_next;
        nf_reg     <= nf_next;
        pf_reg     <= pf_next;
        slot_reg   <= slot_next;
        s_reg      <= s_next;
        status_reg <= status_next;
        start_reg  <= start_next;
    end

    // Busy covers the result cycle, so a new command starts after it.
    assign busy                = (state_reg != ST_IDLE) || done_reg;
    assign done                = done_reg;
    assign result.status       = status_reg;
    assign result.start_unit   = start_reg;
    assign result.used_units   = used_reg;
    assign result.free_extents = fc_reg;

endmodule

### rtl/core/first_fit_unit_allocator_core.sv
// Top level of the first-fit unit allocator with free-extent coalescing.
//
//  Channel   Signals                       Transfer condition
//  command   start, busy, cmd              start && !busy && !cfg_we at a rising edge
//  result    done, result                  done high for one cycle
//  config    cfg_we, cfg_data              cfg_we in the idle state at a rising edge
//
// An allocate walks the free list until an extent fits, marks it used and
// writes any free remainder; list entries behind an extent consumed whole
// move up. A free reads the extent and its neighbours, scans the list for a
// free next extent, writes the merge, and moves list entries up when both
// neighbours join. The walk is set by the single read port of the free-list
// order store. After reset and after every accepted pool_units write, a
// clearing pass sweeps all 256 units of the extent store, then seeds the
// free list; busy stays high throughout. The receiver cannot stall: each
// result is shown for exactly one cycle together with done.
module first_fit_unit_allocator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ffua_pkg::cmd_t              cmd,
    output logic                        done,
    output ffua_pkg::result_t           result,
    input  logic                        cfg_we,
    input  logic [ffua_pkg::CNT_W-1:0]  cfg_data
);

    ffua_pkg::mem_req_t mreq;
    ffua_pkg::mem_rsp_t mrsp;

    // The sequencer owns all bookkeeping; the store holds the three tables.
    ffua_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .mrsp     (mrsp),
        .mreq     (mreq),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    ffua_mem u_mem (
        .clk (clk),
        .req (mreq),
        .rsp (mrsp)
    );

endmodule

### rtl/core/ffua_checker.sv
// Port-level checker for the allocator, bound to the top level.
module ffua_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input ffua_pkg::result_t result
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while not busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result held longer than one cycle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ffua_pkg::STATUS_OK ||
                  result.status == ffua_pkg::STATUS_NO_FIT ||
                  result.status == ffua_pkg::STATUS_BAD))
        else $error("undefined status code");

    a_fail_start: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ffua_pkg::STATUS_OK) |-> result.start_unit == '0)
        else $error("failed request reports a start unit");

endmodule

bind first_fit_unit_allocator_core ffua_checker u_ffua_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

### tb/sv/tb_first_fit_unit_allocator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit unit allocator core.
module tb_first_fit_unit_allocator_core;

    // Clock, reset and the block's ports.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    ffua_pkg::cmd_t cmd = '0;
    logic done;
    ffua_pkg::result_t result;
    logic cfg_we = 1'b0;
    logic [ffua_pkg::CNT_W-1:0] cfg_data = '0;

    always #10 clk = ~clk;

    first_fit_unit_allocator_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // The predictor keeps its own picture of the pool. Lengths sit at the
    // start unit of each extent, the start unit is also tagged at the last
    // unit, and the free list holds free extent starts in list order.
    int unsigned pool_sz;
    int unsigned ext_len [ffua_pkg::UNITS];
    int unsigned ext_tag [ffua_pkg::UNITS];
    bit          ext_is_free [ffua_pkg::UNITS];
    int unsigned free_list [ffua_pkg::UNITS];
    int unsigned free_cnt;
    int unsigned used_cnt;

    // Commands waiting for the driver, and results the predictor expects.
    ffua_pkg::cmd_t    cmd_pending [$];
    ffua_pkg::result_t result_expected [$];
    ffua_pkg::result_t last_pred;

    int unsigned mismatches = 0;
    bit          failed = 1'b0;
    int unsigned cycles = 0;
    bit          hold_off = 1'b0;   // the sender pauses while this is high

    function automatic int unsigned lim(input int unsigned x);
        return (x < ffua_pkg::UNITS) ? x : ffua_pkg::UNITS - 1;
    endfunction

    // Rebuild the pool as one free extent, as a pool_units write does.
    function automatic void pool_reinit(input int unsigned units);
        for (int i = 0; i < ffua_pkg::UNITS; i++)
        begin
            ext_len[i] = 0;
            ext_tag[i] = 0;
            ext_is_free[i] = 1'b0;
            free_list[i] = 0;
        end
        pool_sz = units;
        ext_len[0] = units;
        ext_tag[lim(units - 1)] = 0;
        ext_is_free[0] = 1'b1;
        free_cnt = 1;
        used_cnt = 0;
    endfunction

    function automatic void list_drop(input int unsigned slot);
        if (slot >= free_cnt)
            return;
        for (int unsigned i = slot; i + 1 < free_cnt; i++)
            free_list[i] = free_list[i + 1];
        free_cnt--;
    endfunction

    function automatic logic [1:0] grant_units(input int unsigned bytes,
                                               output int unsigned base);
        int unsigned need;
        int unsigned i;
        int unsigned s;
        int unsigned len;
        int unsigned rest;
        need = (bytes + ffua_pkg::UNIT_BYTES - 1) / ffua_pkg::UNIT_BYTES;
        base = 0;
        if (need == 0)
            return ffua_pkg::STATUS_NO_FIT;
        for (i = 0; i < free_cnt; i++)
            if (ext_len[lim(free_list[i])] >= need)
                break;
        if (i >= free_cnt)
            return ffua_pkg::STATUS_NO_FIT;
        s = lim(free_list[i]);
        len = ext_len[s];
        if (len == need)
        begin
            list_drop(i);
            ext_is_free[s] = 1'b0;
        end
        else
        begin
            // The remainder stays free in the same list slot.
            rest = lim(s + need);
            ext_len[s] = need;
            ext_is_free[s] = 1'b0;
            ext_tag[lim(s + need - 1)] = s;
            ext_len[rest] = len - need;
            ext_is_free[rest] = 1'b1;
            ext_tag[lim(s + len - 1)] = rest;
            free_list[i] = rest;
        end
        used_cnt += need;
        base = s;
        return ffua_pkg::STATUS_OK;
    endfunction

    function automatic logic [1:0] release_units(input int unsigned c);
        int unsigned len;
        int unsigned nx;
        int unsigned p;
        int unsigned nlen;
        int unsigned slot;
        int unsigned last;
        bit nfree;
        bit pfree;
        p = 0;
        nfree = 1'b0;
        pfree = 1'b0;
        if (c >= pool_sz)
            return ffua_pkg::STATUS_BAD;
        len = ext_len[c];
        if (len == 0 || ext_is_free[c])
            return ffua_pkg::STATUS_BAD;
        nx = c + len;
        // A neighbour outside the pool counts as used.
        if (nx < pool_sz && nx < ffua_pkg::UNITS && ext_is_free[nx] && ext_len[nx] != 0)
            nfree = 1'b1;
        if (c > 0)
        begin
            // The extent in front is found by the start tag just before c.
            p = lim(ext_tag[c - 1]);
            if (ext_is_free[p] && ext_len[p] != 0 && p + ext_len[p] == c)
                pfree = 1'b1;
        end
        if (nfree)
        begin
            nlen = ext_len[nx];
            slot = free_cnt;
            for (int unsigned i = 0; i < free_cnt; i++)
                if (free_list[i] == nx)
                begin
                    slot = i;
                    break;
                end
            last = lim(nx + nlen - 1);
            ext_len[nx] = 0;
            ext_is_free[nx] = 1'b0;
            if (pfree)
            begin
                list_drop(slot);
                ext_len[p] += len + nlen;
                ext_tag[last] = p;
                ext_len[c] = 0;
            end
            else
            begin
                if (slot < free_cnt)
                    free_list[slot] = c;
                else if (free_cnt < ffua_pkg::UNITS)
                    free_list[free_cnt++] = c;
                ext_len[c] = len + nlen;
                ext_is_free[c] = 1'b1;
                ext_tag[last] = c;
            end
        end
        else if (pfree)
        begin
            ext_len[p] += len;
            ext_tag[lim(c + len - 1)] = p;
            ext_len[c] = 0;
        end
        else
        begin
            ext_is_free[c] = 1'b1;
            if (free_cnt < ffua_pkg::UNITS)
                free_list[free_cnt++] = c;
        end
        used_cnt = (used_cnt >= len) ? used_cnt - len : 0;
        return ffua_pkg::STATUS_OK;
    endfunction

    function automatic ffua_pkg::result_t predict_result(input ffua_pkg::cmd_t c);
        ffua_pkg::result_t r;
        int unsigned base;
        base = 0;
        if (c.mode == ffua_pkg::MODE_FREE)
            r.status = release_units(c.unit_index);
        else
            r.status = grant_units(c.size_bytes, base);
        r.start_unit = base[ffua_pkg::IDX_W-1:0];
        r.used_units = used_cnt[ffua_pkg::CNT_W-1:0];
        r.free_extents = free_cnt[ffua_pkg::CNT_W-1:0];
        return r;
    endfunction

    // Driver: bursts of transfers with random gaps. When start is high and
    // busy is low at an edge the command is taken, so the next one goes
    // straight onto the port or start drops.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                last_pred = predict_result(cmd);
                result_expected.insert(result_expected.size(), last_pred);
                void'(cmd_pending.pop_front());
            end
            if (start && busy)
            begin
                // Hold the offered command until it is taken.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (cmd_pending.size() > (start && !busy ? 0 : 0) && !hold_off)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    if ($urandom_range(0, 2) == 0)
                        gap_left = $urandom_range(1, 30);
                end
                if (gap_left > 0 && !(start && busy))
                begin
                    start <= 1'b0;
                end
                else if (cmd_pending.size() > 0)
                begin
                    burst_left--;
                    cmd <= cmd_pending[0];
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    always @(posedge clk)
    begin
        ffua_pkg::result_t want;
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (result_expected.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                want = result_expected.pop_front();
                if (result.status !== want.status
                    || result.start_unit !== want.start_unit
                    || result.used_units !== want.used_units
                    || result.free_extents !== want.free_extents)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, result);
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        if (cycles > 2000000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Command builders.
    function automatic ffua_pkg::cmd_t alloc_cmd(input int unsigned bytes);
        ffua_pkg::cmd_t c;
        c = '0;
        c.mode = ffua_pkg::MODE_ALLOC;
        c.size_bytes = bytes[ffua_pkg::SIZE_W-1:0];
        c.unit_index = ffua_pkg::IDX_W'($urandom());
        return c;
    endfunction

    function automatic ffua_pkg::cmd_t free_cmd(input int unsigned u);
        ffua_pkg::cmd_t c;
        c = '0;
        c.mode = ffua_pkg::MODE_FREE;
        c.unit_index = u[ffua_pkg::IDX_W-1:0];
        c.size_bytes = ffua_pkg::SIZE_W'($urandom());
        return c;
    endfunction

    // Append a command at the back of the pending queue.
    function automatic void queue_cmd(input ffua_pkg::cmd_t c);
        cmd_pending.insert(cmd_pending.size(), c);
    endfunction

    // Wait until all commands are taken and all results have come, plus
    // time for the last command to finish before the pool is touched.
    task automatic drain();
        while (cmd_pending.size() != 0 || result_expected.size() != 0 || start)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write pool_units while idle and wait out the clearing pass.
    task automatic set_pool(input int unsigned value);
        int unsigned eff;
        drain();
        cfg_data <= value[ffua_pkg::CNT_W-1:0];
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        eff = (value == 0) ? 1 : ((value > ffua_pkg::UNITS) ? ffua_pkg::UNITS : value);
        pool_reinit(eff);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Mostly sizes that fit a few units, sometimes large, sometimes zero.
    function automatic int unsigned rand_bytes();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return 0;
        if (k == 1)
            return $urandom_range(0, 65535);
        if (k < 4)
            return $urandom_range(1, 64 * 40);
        return $urandom_range(1, 64 * 6);
    endfunction

    // Random phase: allocations and frees of granted extents, with some
    // frees of arbitrary units to exercise the bad-free path.
    task automatic random_phase(input int unsigned count);
        int unsigned granted [$];
        int unsigned pick;
        ffua_pkg::cmd_t c;
        ffua_pkg::result_t r;
        for (int unsigned n = 0; n < count; n++)
        begin
            // Track grants from the predicted outcome so frees hit live extents.
            if (granted.size() > 0 && $urandom_range(0, 99) < 45)
            begin
                pick = $urandom_range(0, granted.size() - 1);
                c = free_cmd(granted[pick]);
                granted.delete(pick);
            end
            else if ($urandom_range(0, 99) < 8)
                c = free_cmd($urandom_range(0, 255));
            else
                c = alloc_cmd(rand_bytes());
            queue_cmd(c);
            // The driver keeps the prediction of the last command taken.
            while (cmd_pending.size() != 0)
                @(posedge clk);
            r = last_pred;
            if (c.mode == ffua_pkg::MODE_ALLOC && r.status == ffua_pkg::STATUS_OK)
                granted.insert(granted.size(), r.start_unit);
        end
    endtask

    initial
    begin
        pool_reinit(ffua_pkg::UNITS);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // Directed: zero size, maximum size, whole pool, bad frees, merges.
        queue_cmd(alloc_cmd(0));
        queue_cmd(alloc_cmd(65535));
        queue_cmd(alloc_cmd(1));
        queue_cmd(alloc_cmd(64));
        queue_cmd(alloc_cmd(65));
        queue_cmd(alloc_cmd(128));
        queue_cmd(free_cmd(1));
        queue_cmd(free_cmd(255));
        queue_cmd(free_cmd(0));
        queue_cmd(free_cmd(0));
        queue_cmd(free_cmd(2));
        queue_cmd(free_cmd(1));
        queue_cmd(alloc_cmd(64 * 256));
        queue_cmd(alloc_cmd(1));
        queue_cmd(free_cmd(0));
        drain();

        // Small pool: out-of-range frees and edge neighbours.
        set_pool(0);
        queue_cmd(alloc_cmd(64));
        queue_cmd(alloc_cmd(64));
        queue_cmd(free_cmd(1));
        queue_cmd(free_cmd(0));
        set_pool(4);
        queue_cmd(alloc_cmd(64));
        queue_cmd(alloc_cmd(64));
        queue_cmd(alloc_cmd(128));
        queue_cmd(free_cmd(1));
        queue_cmd(free_cmd(0));
        queue_cmd(free_cmd(2));
        queue_cmd(free_cmd(4));

        set_pool(511);
        random_phase(150);
        hold_off = 1'b1;
        drain();
        hold_off = 1'b0;
        set_pool(24);
        random_phase(120);
        set_pool(256);
        random_phase(130);

        drain();
        repeat (50) @(posedge clk);
        if (!failed && result_expected.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
